FILE: design/first_fit_page_allocator_top_defines.svh
// assertion macros for the first-fit page allocator
`ifndef FIRST_FIT_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FFPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define FFPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: design/ffpa_pkg.sv
// shared constants and types for the first-fit page allocator
`timescale 1ns / 1ps
package ffpa_pkg;

  localparam int unsigned MaxExtentsDefault = 64;
  localparam int unsigned PageIndexBitsDefault = 20;

  // operation codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_ADD   = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_SHORT = 3'd1;
  localparam logic [2:0] STAT_NOFIT = 3'd2;
  localparam logic [2:0] STAT_FULL  = 3'd3;
  localparam logic [2:0] STAT_BAD   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

FILE: design/first_fit_page_allocator_top.sv
// first-fit page allocator: extent table, scan sequencer and result register
// allocate and free scan the extent table; add and rejected requests skip the scan
// one word at a time: the next word is taken once the sequencer is idle
// the scan reads one table entry per cycle from the extent memory (one read, one write
// port) and compacts the table in the same pass by writing kept entries behind the read
// reset: sync active-high rst empties the table and clears the free total
`timescale 1ns / 1ps
`include "first_fit_page_allocator_top_defines.svh"
module first_fit_page_allocator_top #(
  parameter int unsigned MAX_EXTENTS = ffpa_pkg::MaxExtentsDefault,
  parameter int unsigned PAGE_INDEX_BITS = ffpa_pkg::PageIndexBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // func, page_start, page_count
  input  logic [((2*PAGE_INDEX_BITS+3+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status, alloc_start, free_pages
  output logic [((2*PAGE_INDEX_BITS+4+7)/8)*8-1:0] m_tdata
);
  import ffpa_pkg::*;

  localparam int P = PAGE_INDEX_BITS;
  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int OW = ((2*P+4+7)/8)*8;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_EXTENTS);
  localparam logic [P+1:0] PageSpace = (P+2)'(1) << P;

  state_t state;
  logic [1:0] func;
  logic [P-1:0] bs;
  logic [P:0] cnt, blen;
  logic [P+1:0] bend;
  logic [CW-1:0] count, r, w;
  logic [P:0] total;
  logic [2:0] st;
  logic found, absorbed, ev_vld;
  logic [P-1:0] where;
  logic [P-1:0] rd_s;
  logic [P:0] rd_l;
  logic [P-1:0] mem_s [MAX_EXTENTS];
  logic [P:0] mem_l [MAX_EXTENTS];

  logic rd_en, wr_en, commit, full, fin_ok;
  logic [IW-1:0] wr_addr;
  logic [P-1:0] wr_s;
  logic [P:0] wr_l;
  logic hit_after, hit_before;
  logic [2:0] chk_st;
  logic [2:0] res_st;
  logic [P-1:0] res_start;
  logic [P:0] res_free;

  assign s_tready = (state == S_IDLE);
  assign commit = !m_tvalid || m_tready;
  assign rd_en = (state == S_SCAN) && (r < count);
  assign hit_after = (bend == {2'b00, rd_s});
  assign hit_before = (({2'b00, rd_s} + {1'b0, rd_l}) == {2'b00, bs});
  assign full = (func != FUNC_ALLOC) && (count == MaxCnt) &&
                ((func == FUNC_ADD) || !absorbed);
  assign fin_ok = (st == STAT_OK) && !full && ((func != FUNC_ALLOC) || found);

  // request checks before the scan
  always_comb begin
    chk_st = STAT_OK;
    if (func == FUNC_ALLOC) begin
      if (cnt == '0) begin
        chk_st = STAT_BAD;
      end else if (cnt > total) begin
        chk_st = STAT_SHORT;
      end
    end else if (func == FUNC_FREE || func == FUNC_ADD) begin
      if (cnt == '0 || ({2'b00, bs} + {1'b0, cnt}) > PageSpace ||
          ({1'b0, total} + {1'b0, cnt}) > PageSpace) begin
        chk_st = STAT_BAD;
      end
    end else begin
      chk_st = STAT_BAD;
    end
  end

  // result word fields
  always_comb begin
    res_st = st;
    res_start = '0;
    res_free = total;
    if (st == STAT_OK) begin
      if (func == FUNC_ALLOC) begin
        if (found) begin
          res_start = where;
          res_free = total - cnt;
        end else begin
          res_st = STAT_NOFIT;
        end
      end else if (full) begin
        res_st = STAT_FULL;
      end else begin
        res_free = total + cnt;
      end
    end
  end

  // memory write select: scan write-back or tail append
  always_comb begin
    wr_en = 1'b0;
    wr_addr = w[IW-1:0];
    wr_s = rd_s;
    wr_l = rd_l;
    if (state == S_SCAN && ev_vld) begin
      if (func == FUNC_ALLOC) begin
        if (!found && rd_l >= cnt) begin
          wr_en = (rd_l != cnt);
          wr_s = rd_s + cnt[P-1:0];
          wr_l = rd_l - cnt;
        end else begin
          wr_en = 1'b1;
        end
      end else begin
        wr_en = !(hit_after || hit_before);
      end
    end else if (state == S_FIN && commit && fin_ok && func != FUNC_ALLOC) begin
      wr_en = 1'b1;
      wr_s = bs;
      wr_l = blen;
    end
  end

  // extent memory with registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_s <= mem_s[r[IW-1:0]];
      rd_l <= mem_l[r[IW-1:0]];
    end
    if (wr_en) begin
      mem_s[wr_addr] <= wr_s;
      mem_l[wr_addr] <= wr_l;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      m_tvalid <= 1'b0;
      ev_vld <= 1'b0;
    end else begin
      if (state == S_FIN && commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func <= s_tdata[1:0];
            bs <= s_tdata[P+1:2];
            cnt <= s_tdata[2*P+2:P+2];
            state <= S_CHK;
          end
        end
        S_CHK: begin
          r <= '0;
          w <= (func == FUNC_ADD) ? count : '0;
          ev_vld <= 1'b0;
          found <= 1'b0;
          absorbed <= 1'b0;
          blen <= cnt;
          bend <= {2'b00, bs} + {1'b0, cnt};
          st <= chk_st;
          state <= (chk_st != STAT_OK || func == FUNC_ADD) ? S_FIN : S_SCAN;
        end
        S_SCAN: begin
          ev_vld <= rd_en;
          if (rd_en) r <= r + 1'b1;
          if (ev_vld) begin
            if (wr_en) w <= w + 1'b1;
            if (func == FUNC_ALLOC) begin
              if (!found && rd_l >= cnt) begin
                found <= 1'b1;
                where <= rd_s;
              end
            end else if (hit_after) begin
              blen <= blen + rd_l;
              bend <= bend + {1'b0, rd_l};
              absorbed <= 1'b1;
            end else if (hit_before) begin
              bs <= rd_s;
              blen <= blen + rd_l;
              absorbed <= 1'b1;
            end
          end
          if (!rd_en && !ev_vld) state <= S_FIN;
        end
        S_FIN: begin
          if (commit) begin
            m_tdata <= OW'({res_free, res_start, res_st});
            if (fin_ok) begin
              count <= (func == FUNC_ALLOC) ? w : w + 1'b1;
              total <= res_free;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFPA_ASSERT_NOW(a_count_range, 1'b1, count <= MaxCnt)
  `FFPA_ASSERT_NOW(a_write_behind, state == S_SCAN, w <= r)
  `FFPA_ASSERT_NEXT(a_accept_chk, s_tvalid && s_tready, state == S_CHK)

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the first-fit page allocator
`timescale 1ns / 1ps
module testbench;
  import ffpa_pkg::*;

  localparam int unsigned EXT_DEPTH = 64;
  localparam logic [20:0] SPACE = 21'h100000;
  localparam int unsigned IDLE_LIMIT = 5000;

  // packed from the top bit down, so status sits in the lowest bits
  typedef struct packed {
    logic [20:0] free_pages;
    logic [19:0] alloc_start;
    logic [2:0] status;
  } alloc_result_t;

  typedef struct {
    logic [19:0] start;
    logic [20:0] count;
  } extent_t;

  // page table predictor and queue of expected responses
  class page_table_scoreboard;
    logic [19:0] ext_start[EXT_DEPTH];
    logic [20:0] ext_len[EXT_DEPTH];
    int unsigned ext_cnt;
    logic [20:0] total;
    alloc_result_t pending_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_seen[8];

    function new();
      ext_cnt = 0;
      total = '0;
      mismatches = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void remove_slot(int unsigned idx);
      for (int unsigned k = idx; k + 1 < ext_cnt; k++) begin
        ext_start[k] = ext_start[k+1];
        ext_len[k] = ext_len[k+1];
      end
      ext_cnt--;
    endfunction

    function logic [2:0] do_alloc(logic [20:0] cnt, output logic [19:0] where);
      where = '0;
      if (cnt == 0) return STAT_BAD;
      if (cnt > total) return STAT_SHORT;
      for (int unsigned k = 0; k < ext_cnt; k++) begin
        if (ext_len[k] >= cnt) begin
          where = ext_start[k];
          if (ext_len[k] == cnt) remove_slot(k);
          else begin
            ext_start[k] = ext_start[k] + cnt[19:0];
            ext_len[k] = ext_len[k] - cnt;
          end
          total = total - cnt;
          return STAT_OK;
        end
      end
      return STAT_NOFIT;
    endfunction

    function logic [2:0] do_release(logic [19:0] s, logic [20:0] cnt, bit merge);
      logic [21:0] bs, bl;
      bit adj;
      int unsigned k;
      if (cnt == 0 || {2'b0, s} + cnt > SPACE || {1'b0, total} + cnt > SPACE)
        return STAT_BAD;
      adj = 0;
      for (k = 0; k < ext_cnt; k++)
        if ({2'b0, s} + cnt == ext_start[k] || {2'b0, ext_start[k]} + ext_len[k] == s)
          adj = 1;
      if (ext_cnt >= EXT_DEPTH && (!merge || !adj)) return STAT_FULL;
      bs = s;
      bl = cnt;
      if (merge) begin
        k = 0;
        while (k < ext_cnt) begin
          if (bs + bl == ext_start[k]) begin
            bl += ext_len[k];
            remove_slot(k);
          end else if ({2'b0, ext_start[k]} + ext_len[k] == bs) begin
            bs = ext_start[k];
            bl += ext_len[k];
            remove_slot(k);
          end else k++;
        end
      end
      ext_start[ext_cnt] = bs[19:0];
      ext_len[ext_cnt] = bl[20:0];
      ext_cnt++;
      total = total + cnt;
      return STAT_OK;
    endfunction

    // predict the response to an accepted request word
    function alloc_result_t note_request(logic [1:0] fn, logic [19:0] s,
                                         logic [20:0] cnt);
      alloc_result_t r;
      logic [19:0] where;
      where = '0;
      case (fn)
        FUNC_ALLOC: r.status = do_alloc(cnt, where);
        FUNC_FREE: r.status = do_release(s, cnt, 1);
        FUNC_ADD: r.status = do_release(s, cnt, 0);
        default: r.status = STAT_BAD;
      endcase
      r.alloc_start = (r.status == STAT_OK) ? where : '0;
      r.free_pages = total;
      pending_q.push_back(r);
      status_seen[r.status]++;
      return r;
    endfunction

    function void check_response(alloc_result_t act);
      alloc_result_t exp_r;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", act);
        return;
      end
      exp_r = pending_q.pop_front();
      if (act.status !== exp_r.status || act.alloc_start !== exp_r.alloc_start ||
          act.free_pages !== exp_r.free_pages) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d start %0h free %0h, got %0d %0h %0h",
                   exp_r.status, exp_r.alloc_start, exp_r.free_pages,
                   act.status, act.alloc_start, act.free_pages);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [47:0] m_tdata;

  page_table_scoreboard sb = new();
  extent_t held_q[$];
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  bit hold_off_req = 0;
  bit no_gaps = 0;

  first_fit_page_allocator_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("** first_fit_page_allocator_top: FAILED **");
      $finish;
    end
  end

  // send one request word, remembering allocated extents for later frees
  task automatic send_request(logic [1:0] fn, logic [19:0] s, logic [20:0] cnt);
    int unsigned gap;
    alloc_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'b0, cnt, s, fn};
    do @(posedge clk); while (!s_tready);
    r = sb.note_request(fn, s, cnt);
    if (fn == FUNC_ALLOC && r.status == STAT_OK) held_q.push_back('{r.alloc_start, cnt});
    sent++;
  endtask

  // response side with random back-pressure and one long hold-off
  initial begin
    int unsigned gap;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        gap = 400;
      end else gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_response(m_tdata[43:0]);
    end
  end

  initial begin
    int unsigned pick, idx;
    extent_t e;
    logic [20:0] c;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: rejects, whole page space, range and overflow checks
    send_request(FUNC_ALLOC, 20'h0, 21'd0);
    send_request(2'd3, 20'hfffff, 21'h1fffff);
    send_request(FUNC_ALLOC, 20'h0, 21'd1);
    send_request(FUNC_ADD, 20'h0, SPACE);
    send_request(FUNC_ALLOC, 20'h0, SPACE);
    send_request(FUNC_ADD, 20'hfffff, 21'd2);
    send_request(FUNC_FREE, 20'h5, 21'd0);
    held_q.delete();
    // fill the table with separated extents
    for (int i = 0; i < EXT_DEPTH; i++) send_request(FUNC_ADD, 20'(i * 4), 21'd2);
    send_request(FUNC_ADD, 20'h800, 21'd1);
    send_request(FUNC_FREE, 20'h800, 21'd1);
    // adjacent free while full merges both neighbors
    send_request(FUNC_FREE, 20'h2, 21'd2);
    send_request(FUNC_ALLOC, 20'h0, 21'd100);
    send_request(FUNC_FREE, 20'h0, SPACE);
    send_request(FUNC_ALLOC, 20'h0, 21'd3);
    send_request(FUNC_ALLOC, 20'h0, 21'd2);
    send_request(FUNC_ALLOC, 20'h0, 21'd1000);
    send_request(FUNC_ADD, 20'h80000, 21'h40000);

    // random mix: mostly alloc/free pairs, some adds and malformed requests
    for (int n = 0; n < 1800; n++) begin
      if (n % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == 600) hold_off_req = 1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        c = ($urandom_range(0, 19) == 0) ? 21'($urandom) : 21'($urandom_range(1, 64));
        send_request(FUNC_ALLOC, 20'($urandom), c);
      end else if (pick < 75 && held_q.size() > 0) begin
        idx = $urandom_range(0, held_q.size() - 1);
        e = held_q[idx];
        held_q.delete(idx);
        send_request(FUNC_FREE, e.start, e.count);
      end else if (pick < 85) begin
        send_request(FUNC_ADD, 20'($urandom), 21'($urandom_range(1, 256)));
      end else begin
        case ($urandom_range(0, 3))
          0: send_request(2'($urandom_range(0, 3)), 20'($urandom), 21'd0);
          1: send_request(2'd3, 20'($urandom), 21'($urandom));
          2: send_request(FUNC_FREE, 20'($urandom), 21'($urandom));
          default: send_request(FUNC_ADD, 20'($urandom | 20'h80000), 21'($urandom));
        endcase
      end
    end
    s_tvalid <= 0;

    wait (sb.pending_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d requests: ok %0d, short %0d, no fit %0d, full %0d, rejected %0d",
             sent, sb.status_seen[STAT_OK], sb.status_seen[STAT_SHORT],
             sb.status_seen[STAT_NOFIT], sb.status_seen[STAT_FULL], sb.status_seen[STAT_BAD]);
    $display("responses checked %0d, mismatches %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("** first_fit_page_allocator_top: PASSED **");
    end else begin
      $display("** first_fit_page_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/ffpa_pkg.sv
design/first_fit_page_allocator_top.sv
tb/testbench.sv
